[rtl/core/bdsl_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded deque / sorted list package
// Request and response types, operation and status codes, compare unit modes.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 6;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
  localparam logic [OP_W-1:0] OP_SORTED_ADD = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        count;
  } out_rsp_t;

  typedef enum logic [1:0] {
    CM_COPY,
    CM_MATCH,
    CM_BUBBLE
  } cmp_mode_e;

  typedef struct packed {
    logic wr_en;
    logic swap;
  } cmp_ctl_t;

endpackage

[rtl/core/bdsl_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdsl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bdsl_cmp.sv]
// ----------------------------------------------------------------------------
// Bounded deque compare unit
// Shared select / compare step used by shifts, value removal and sort passes.
// ----------------------------------------------------------------------------
module bdsl_cmp
  import bdsl_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 16
) (
  input  cmp_mode_e             mode_i,
  input  logic                  first_i,
  input  logic [VALUE_BITS-1:0] key_i,
  input  logic [VALUE_BITS-1:0] carry_i,
  input  logic [VALUE_BITS-1:0] rdata_i,
  output cmp_ctl_t              ctl_o,
  output logic [VALUE_BITS-1:0] wdata_o,
  output logic [VALUE_BITS-1:0] carry_o
);

  logic less;

  assign less = $signed(rdata_i) < $signed(carry_i);

  always_comb begin
    ctl_o   = '0;
    wdata_o = rdata_i;
    carry_o = carry_i;
    case (mode_i)
      CM_COPY: begin
        ctl_o.wr_en = 1'b1;
      end
      CM_MATCH: begin
        ctl_o.wr_en = (rdata_i != key_i);
      end
      CM_BUBBLE: begin
        if (first_i) begin
          carry_o = rdata_i;
        end else if (less) begin
          ctl_o.wr_en = 1'b1;
          ctl_o.swap  = 1'b1;
        end else begin
          ctl_o.wr_en = 1'b1;
          wdata_o     = carry_i;
          carry_o     = rdata_i;
        end
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

endmodule

[rtl/core/bounded_deque_sorted_list_core.sv]
// ----------------------------------------------------------------------------
// Bounded deque / sorted list core
// Deque of signed values with push/pop at both ends, removal of all equal
// entries and insertion followed by an ascending sort, on one entry RAM.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   request | in        | in_valid_i / in_stall_o  | in_req_i  (op, value)
//   result  | out       | out_valid_o / out_stall_i| out_rsp_o (value_out,
//           |           |                          |  status, count)
//
// Push back, full or empty cases and unused codes go straight to completion;
// pops first capture a RAM read. Push front, pop front and delete also stream
// over the stored entries. Sorted add: bubble passes of shrinking length,
// stopping early when a pass makes no swap.
// Reset empties the store at once; there is no clearing pass.
// A request is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module bounded_deque_sorted_list_core
  import bdsl_pkg::*;
#(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
  localparam int unsigned NW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAPTURE,
    S_STREAM,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [VALUE_BITS-1:0] vout_q, vout_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         rd_q, rd_d;
  logic [CW-1:0]         left_q, left_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         limit_q, limit_d;
  logic                  vld_q, vld_d;
  logic                  asc_q, asc_d;
  logic                  first_q, first_d;
  logic                  swap_q, swap_d;
  cmp_mode_e             mode_q, mode_d;
  logic [VALUE_BITS-1:0] carry_q, carry_d;
  logic                  out_valid_q, out_valid_d;
  out_rsp_t              out_q, out_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  cmp_ctl_t              cmp_ctl;
  logic [VALUE_BITS-1:0] cmp_wdata;
  logic [VALUE_BITS-1:0] cmp_carry;

  logic [XW-1:0]         key_ext;
  logic [VALUE_BITS-1:0] in_key;
  logic [XW-1:0]         vout_ext;
  logic [NW-1:0]         cnt_ext;
  logic                  accept;
  logic                  full;
  logic                  empty;

  assign key_ext  = XW'(in_req_i.value);
  assign in_key   = key_ext[VALUE_BITS-1:0];
  assign vout_ext = XW'(vout_q);
  assign cnt_ext  = NW'(count_q);
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  bdsl_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bdsl_cmp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .mode_i  (mode_q),
    .first_i (first_q),
    .key_i   (key_q),
    .carry_i (carry_q),
    .rdata_i (ram_rdata),
    .ctl_o   (cmp_ctl),
    .wdata_o (cmp_wdata),
    .carry_o (cmp_carry)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    vout_d      = vout_q;
    status_d    = status_q;
    count_d     = count_q;
    rd_d        = rd_q;
    left_d      = left_q;
    wr_d        = wr_q;
    limit_d     = limit_q;
    vld_d       = 1'b0;
    asc_d       = asc_q;
    first_d     = first_q;
    swap_d      = swap_q;
    mode_d      = mode_q;
    carry_d     = carry_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = in_req_i.op;
          key_d    = in_key;
          vout_d   = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (in_req_i.op)
            OP_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d   = count_q + 1'b1;
                vout_d    = in_key;
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_key;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
                vout_d  = in_key;
                if (empty) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = in_key;
                end else begin
                  asc_d   = 1'b0;
                  mode_d  = CM_COPY;
                  rd_d    = AW'(count_q - 1'b1);
                  left_d  = count_q;
                  wr_d    = count_q;
                  state_d = S_STREAM;
                end
              end
            end
            OP_SORTED_ADD: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d   = count_q + 1'b1;
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_key;
                if (!empty) begin
                  asc_d   = 1'b1;
                  mode_d  = CM_BUBBLE;
                  rd_d    = '0;
                  left_d  = count_q + 1'b1;
                  limit_d = count_q + 1'b1;
                  wr_d    = '0;
                  first_d = 1'b1;
                  swap_d  = 1'b0;
                  state_d = S_STREAM;
                end
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d   = count_q - 1'b1;
                ram_re    = 1'b1;
                ram_raddr = AW'(count_q - 1'b1);
                state_d   = S_CAPTURE;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d   = count_q - 1'b1;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_CAPTURE;
              end
            end
            OP_DELETE: begin
              if (!empty) begin
                asc_d   = 1'b1;
                mode_d  = CM_MATCH;
                rd_d    = '0;
                left_d  = count_q;
                wr_d    = '0;
                state_d = S_STREAM;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_CAPTURE: begin
        vout_d  = ram_rdata;
        state_d = S_DONE;
        if (op_q == OP_POP_FRONT && !empty) begin
          asc_d   = 1'b1;
          mode_d  = CM_COPY;
          rd_d    = AW'(1);
          left_d  = count_q;
          wr_d    = '0;
          state_d = S_STREAM;
        end
      end

      S_STREAM: begin
        if (left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = rd_q;
          rd_d      = asc_q ? rd_q + 1'b1 : rd_q - 1'b1;
          left_d    = left_q - 1'b1;
          vld_d     = 1'b1;
        end
        if (vld_q) begin
          carry_d = cmp_carry;
          first_d = 1'b0;
          if (cmp_ctl.swap) begin
            swap_d = 1'b1;
          end
          if (cmp_ctl.wr_en) begin
            ram_we    = 1'b1;
            ram_waddr = wr_q[AW-1:0];
            ram_wdata = cmp_wdata;
            wr_d      = asc_q ? wr_q + 1'b1 : wr_q - 1'b1;
          end
        end
        if (left_q == '0 && !vld_q) begin
          state_d = S_DONE;
          case (op_q)
            OP_PUSH_FRONT: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = key_q;
            end
            OP_DELETE: begin
              count_d = wr_q;
            end
            OP_SORTED_ADD: begin
              ram_we    = 1'b1;
              ram_waddr = wr_q[AW-1:0];
              ram_wdata = carry_q;
              if (swap_q && limit_q > CW'(2)) begin
                limit_d = limit_q - 1'b1;
                left_d  = limit_q - 1'b1;
                rd_d    = '0;
                wr_d    = '0;
                first_d = 1'b1;
                swap_d  = 1'b0;
                state_d = S_STREAM;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d     = 1'b1;
          out_d.value_out = vout_ext[VAL_W-1:0];
          out_d.status    = status_q;
          out_d.count     = cnt_ext[CNT_W-1:0];
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    vout_q   <= vout_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    left_q   <= left_d;
    wr_q     <= wr_d;
    limit_q  <= limit_d;
    asc_q    <= asc_d;
    first_q  <= first_d;
    swap_q   <= swap_d;
    mode_q   <= mode_d;
    carry_q  <= carry_d;
    out_q    <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
    else $error("RAM read and write at one address");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("request accepted without leaving idle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");

  a_stream_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == S_STREAM))
    else $error("read data pending outside streaming");
`endif

endmodule
